[rtl/core/crm_pkg.sv]
package crm_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // field widths fixed by the item format
  localparam int LEN_W       = 10;
  localparam int ENTRY_IDX_W = 9;
  localparam int CP_W        = 21;
  localparam int DELTA_W     = 22;

  // code point constants
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;

  // item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  // register map (word index taken from paddr[2])
  localparam int          CFG_ADDR_W       = 3;
  localparam logic [0:0]  REG_TABLE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    CASE_UPPER   = 2'd0,
    CASE_LOWER   = 2'd1,
    CASE_TITLE   = 2'd2,
    CASE_INVALID = 2'd3
  } case_sel_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [CP_W-1:0]    lo;
    logic [CP_W-1:0]    hi;
    logic [DELTA_W-1:0] d_upper;
    logic [DELTA_W-1:0] d_lower;
    logic [DELTA_W-1:0] d_title;
  } crm_entry_t;

  typedef struct packed {
    logic [CP_W-1:0] mapped;
    logic            found;
    logic            case_error;
  } crm_result_t;

endpackage

[rtl/core/crm_alu.sv]
module crm_alu
  import crm_pkg::*;
(
  input  alu_op_t         op,
  input  logic [CP_W-1:0] a,
  input  logic [CP_W-1:0] b,
  output logic [CP_W-1:0] sum,
  output logic            carry
);

  logic [CP_W-1:0] b_eff;
  logic [CP_W:0]   full;

  // one adder: subtract is a plus inverted b plus one, carry set means no borrow
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_eff} + {{CP_W{1'b0}}, (op == ALU_SUB)};
  assign sum   = full[CP_W-1:0];
  assign carry = full[CP_W];

endmodule

[rtl/core/crm_table.sv]
module crm_table
  import crm_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  crm_entry_t       wdata,
  input  logic [IDX_W-1:0] raddr,
  output crm_entry_t       rdata
);

  crm_entry_t mem [TABLE_DEPTH];
  crm_entry_t rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/crm_seq.sv]
module crm_seq
  import crm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             func,
  input  logic [CP_W-1:0]  code_point,
  input  case_sel_t        which_case,
  input  logic [LEN_W-1:0] table_length,
  input  crm_entry_t       rdata,
  output logic [IDX_W-1:0] raddr,
  output logic             ready,
  output logic             res_valid,
  output crm_result_t      res,
  input  logic             res_take
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CONV,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] m_r, m_nxt;
  logic [CP_W-1:0]  cp_r, cp_nxt;
  case_sel_t        sel_r, sel_nxt;
  logic [CP_W-1:0]  off_r, off_nxt;
  crm_result_t      res_r, res_nxt;

  logic [CNT_W-1:0] hi_init;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] lo_step, hi_step;
  logic [DELTA_W-1:0] delta_sel;
  logic             alt_seq;
  logic             in_range;

  alu_op_t          alu_op;
  logic [CP_W-1:0]  alu_a, alu_b, alu_sum;
  logic             alu_carry;

  crm_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // clamp the searched length to the table depth
  always_comb begin
    if (32'(table_length) > TABLE_DEPTH) begin
      hi_init = CNT_W'(TABLE_DEPTH);
    end else begin
      hi_init = CNT_W'(table_length);
    end
  end

  // delta of the selected case and the alternating-sequence mark
  always_comb begin
    case (sel_r)
      CASE_UPPER: delta_sel = rdata.d_upper;
      CASE_LOWER: delta_sel = rdata.d_lower;
      default:    delta_sel = rdata.d_title;
    endcase
  end

  assign alt_seq  = !delta_sel[DELTA_W-1] && (delta_sel[CP_W-1:0] > MAX_CP);
  assign in_range = alu_carry && (cp_r <= rdata.hi);

  // operand select for the shared adder
  always_comb begin
    if (state_r == S_CONV) begin
      alu_op = ALU_ADD;
      alu_a  = alt_seq ? rdata.lo : cp_r;
      alu_b  = alt_seq ? {off_r[CP_W-1:1], sel_r[0]} : delta_sel[CP_W-1:0];
    end else begin
      alu_op = ALU_SUB;
      alu_a  = cp_r;
      alu_b  = rdata.lo;
    end
  end

  // bounds after a miss
  always_comb begin
    lo_step = lo_r;
    hi_step = hi_r;
    if (!alu_carry) begin
      hi_step = m_r;
    end else begin
      lo_step = m_r + CNT_W'(1);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    m_nxt     = m_r;
    cp_nxt    = cp_r;
    sel_nxt   = sel_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    mid_sum   = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cp_nxt  = code_point;
          sel_nxt = which_case;
          if (func == FUNC_LOAD) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else if (which_case == CASE_INVALID) begin
            res_nxt.mapped     = REPLACEMENT_CP;
            res_nxt.found      = 1'b0;
            res_nxt.case_error = 1'b1;
            state_nxt          = S_DONE;
          end else if (hi_init == '0) begin
            res_nxt.mapped     = code_point;
            res_nxt.found      = 1'b0;
            res_nxt.case_error = 1'b0;
            state_nxt          = S_DONE;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = hi_init;
            m_nxt     = hi_init >> 1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (in_range) begin
          // keep the read address so the entry stays on the port
          off_nxt   = alu_sum;
          state_nxt = S_CONV;
        end else begin
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_sum = {1'b0, lo_step} + {1'b0, hi_step};
          m_nxt   = mid_sum[CNT_W:1];
          if (lo_step >= hi_step) begin
            res_nxt.mapped     = cp_r;
            res_nxt.found      = 1'b0;
            res_nxt.case_error = 1'b0;
            state_nxt          = S_DONE;
          end
        end
      end
      S_CONV: begin
        res_nxt.mapped     = alu_sum;
        res_nxt.found      = 1'b1;
        res_nxt.case_error = 1'b0;
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    m_r   <= m_nxt;
    cp_r  <= cp_nxt;
    sel_r <= sel_nxt;
    off_r <= off_nxt;
    res_r <= res_nxt;
  end

  assign raddr     = m_nxt[IDX_W-1:0];
  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef SYNTH
  a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r < hi_r && m_r >= lo_r && m_r < hi_r))
    else $error("probe index outside search bounds");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !(res_r.found && res_r.case_error))
    else $error("found and case error both set");

  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.case_error) |-> (res_r.mapped == REPLACEMENT_CP))
    else $error("case error without replacement character");

  a_conv_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> ($past(state_r) == S_PROBE && $stable(m_r)))
    else $error("convert step without a preceding hit");
`endif

endmodule

[rtl/core/case_range_mapper.sv]
// Case range mapper. A load beat (in_tuser[0] = 0) writes one table entry and
// yields an all-zero result through the done state and the output register.
// A map beat binary-searches the first table_length entries (clamped to 512)
// for the range that holds code_point and adds the selected case delta,
// wrapping to 21 bits; an alternating-sequence delta sets or clears the low
// bit of the offset from the range start. A map beat is accepted, then probes
// the table (at most ceil(log2(n+1)) probes, 10 for a full table), then adds
// the delta in the convert step and passes through the output register; a
// miss skips the add step. The single registered read port of the table
// yields one entry per cycle, one per probe. An invalid case selector or an
// empty table answers through the done state without probing. The input
// is not ready while an item is in flight. Table entries power up undefined;
// table_length must cover only written slots.
module case_range_mapper
  import crm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[8:0], entry_lo[29:9], entry_hi[50:30], delta_upper[72:51],
  // delta_lower[94:73], delta_title[116:95], code_point[137:117], zero fill
  input  logic [143:0]          in_tdata,
  // func[0], which_case[2:1]
  input  logic [2:0]            in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mapped_code_point[20:0], zero fill
  output logic [23:0]           out_tdata,
  // found[0], case_error[1]
  output logic [1:0]            out_tuser,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic             in_accept;
  logic             func;
  logic [CP_W-1:0]  code_point;
  case_sel_t        which_case;
  logic [ENTRY_IDX_W-1:0] entry_index;
  crm_entry_t       wentry;
  logic             tbl_we;
  logic [IDX_W-1:0] raddr;
  crm_entry_t       rdata;

  logic             seq_ready;
  logic             res_valid;
  crm_result_t      res;
  logic             res_take;

  logic [LEN_W-1:0] table_length_r;
  logic             cfg_write;

  logic             out_valid_r;
  crm_result_t      out_res_r;

  // input beat unpacking
  assign in_accept      = in_tvalid && in_tready;
  assign func           = in_tuser[0];
  assign which_case     = case_sel_t'(in_tuser[2:1]);
  assign entry_index    = in_tdata[8:0];
  assign wentry.lo      = in_tdata[29:9];
  assign wentry.hi      = in_tdata[50:30];
  assign wentry.d_upper = in_tdata[72:51];
  assign wentry.d_lower = in_tdata[94:73];
  assign wentry.d_title = in_tdata[116:95];
  assign code_point     = in_tdata[137:117];

  assign tbl_we = in_accept && (func == FUNC_LOAD) && (32'(entry_index) < TABLE_DEPTH);

  crm_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_W'(entry_index)),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  crm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_accept),
    .func         (func),
    .code_point   (code_point),
    .which_case   (which_case),
    .table_length (table_length_r),
    .rdata        (rdata),
    .raddr        (raddr),
    .ready        (seq_ready),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  assign in_tready = seq_ready;

  // configuration register
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_write && (cfg_paddr[2] == REG_TABLE_LENGTH)) begin
      table_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_LENGTH) ? 32'(table_length_r) : 32'd0;

  // output register
  assign res_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.mapped};
  assign out_tuser  = {out_res_r.case_error, out_res_r.found};

endmodule

[tb/tb_case_range_mapper.sv]
module tb_case_range_mapper;
  import crm_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 20;
  localparam int FULL_PHASE  = 7;
  localparam int SLOT_SPAN   = 2176;
  localparam logic [DELTA_W-1:0]    ALT_DELTA = 22'h110000;
  localparam logic [CFG_ADDR_W-1:0] LEN_ADDR  = CFG_ADDR_W'({REG_TABLE_LENGTH, 2'b00});

  typedef struct {
    logic                   func;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [CP_W-1:0]        lo;
    logic [CP_W-1:0]        hi;
    logic [DELTA_W-1:0]     du;
    logic [DELTA_W-1:0]     dl;
    logic [DELTA_W-1:0]     dt;
    logic [CP_W-1:0]        cp;
    case_sel_t              sel;
  } beat_t;

  typedef struct {
    bit               reg_write;
    logic [LEN_W-1:0] len;
    beat_t            b;
    bit               typed;
    crm_result_t      want;
  } step_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [143:0]          in_tdata    = '0;
  logic [2:0]            in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [23:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // shadow copy of the range table and its length
  logic [CP_W-1:0]    lo_mem [TABLE_DEPTH];
  logic [CP_W-1:0]    hi_mem [TABLE_DEPTH];
  logic [DELTA_W-1:0] du_mem [TABLE_DEPTH];
  logic [DELTA_W-1:0] dl_mem [TABLE_DEPTH];
  logic [DELTA_W-1:0] dt_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]   tbl_len = '0;

  // sorted layout that the random part loads slot by slot
  logic [CP_W-1:0] plan_lo [TABLE_DEPTH];
  logic [CP_W-1:0] plan_hi [TABLE_DEPTH];

  crm_result_t pending_results[$];
  int          errors         = 0;
  bit          quiet          = 1'b0;
  int          src_gap_pct    = 20;
  int          sink_stall_pct = 20;
  int          sink_hold      = 0;

  case_range_mapper u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // delta mix: plain zero, alternating marker, small offsets, anything in range
  function automatic logic [DELTA_W-1:0] rand_delta();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = 0;
      3, 4: return ALT_DELTA;
      5, 6, 7: v = $urandom_range(0, 200) - 100;
      default: v = $urandom_range(0, 2228223) - 1114111;
    endcase
    return v[DELTA_W-1:0];
  endfunction

  // every field random, so the fields a beat ignores still toggle
  function automatic beat_t random_beat();
    beat_t b;
    b.func = 1'($urandom_range(0, 1));
    b.idx  = ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    b.lo   = CP_W'($urandom_range(0, MAX_CP));
    b.hi   = CP_W'($urandom_range(0, MAX_CP));
    b.du   = rand_delta();
    b.dl   = rand_delta();
    b.dt   = rand_delta();
    b.cp   = CP_W'($urandom_range(0, MAX_CP));
    b.sel  = case_sel_t'($urandom_range(0, 2));
    return b;
  endfunction

  function automatic beat_t plan_beat(int slot);
    beat_t b;
    b      = random_beat();
    b.func = FUNC_LOAD;
    b.idx  = ENTRY_IDX_W'(slot);
    b.lo   = plan_lo[slot];
    b.hi   = plan_hi[slot];
    return b;
  endfunction

  // table update for a load beat, binary search and delta add for a map beat
  function automatic crm_result_t case_map_predict(beat_t b);
    crm_result_t        r;
    int unsigned        lo_bound;
    int unsigned        hi_bound;
    int unsigned        mid;
    logic [DELTA_W-1:0] raw;
    logic [CP_W-1:0]    off;
    r = '0;
    if (b.func == FUNC_LOAD) begin
      lo_mem[b.idx] = b.lo;
      hi_mem[b.idx] = b.hi;
      du_mem[b.idx] = b.du;
      dl_mem[b.idx] = b.dl;
      dt_mem[b.idx] = b.dt;
      return r;
    end
    if (b.sel == CASE_INVALID) begin
      r.mapped     = REPLACEMENT_CP;
      r.case_error = 1'b1;
      return r;
    end
    lo_bound = 0;
    hi_bound = (tbl_len > TABLE_DEPTH) ? TABLE_DEPTH : tbl_len;
    while (lo_bound < hi_bound) begin
      mid = (lo_bound + hi_bound) >> 1;
      if (lo_mem[mid] <= b.cp && b.cp <= hi_mem[mid]) begin
        raw = (b.sel == CASE_UPPER) ? du_mem[mid] :
              (b.sel == CASE_LOWER) ? dl_mem[mid] : dt_mem[mid];
        if ($signed(raw) > $signed({1'b0, MAX_CP})) begin
          // alternating run: low bit of the offset picks upper or lower
          off      = ((b.cp - lo_mem[mid]) & ~CP_W'(1)) | CP_W'(b.sel == CASE_LOWER);
          r.mapped = lo_mem[mid] + off;
        end else begin
          r.mapped = b.cp + raw[CP_W-1:0];
        end
        r.found = 1'b1;
        return r;
      end
      if (b.cp < lo_mem[mid]) hi_bound = mid;
      else lo_bound = mid + 1;
    end
    r.mapped = b.cp;
    return r;
  endfunction

  // directed table rows
  function automatic step_t load_step(logic [ENTRY_IDX_W-1:0] idx, logic [CP_W-1:0] lo,
                                      logic [CP_W-1:0] hi, logic [DELTA_W-1:0] du,
                                      logic [DELTA_W-1:0] dl, logic [DELTA_W-1:0] dt);
    step_t s;
    s.reg_write = 1'b0;
    s.len       = '0;
    s.b         = random_beat();
    s.b.func    = FUNC_LOAD;
    s.b.idx     = idx;
    s.b.lo      = lo;
    s.b.hi      = hi;
    s.b.du      = du;
    s.b.dl      = dl;
    s.b.dt      = dt;
    s.typed     = 1'b1;
    s.want      = '0;
    return s;
  endfunction

  function automatic step_t map_step(logic [CP_W-1:0] cp, case_sel_t sel);
    step_t s;
    s.reg_write = 1'b0;
    s.len       = '0;
    s.b         = random_beat();
    s.b.func    = FUNC_MAP;
    s.b.cp      = cp;
    s.b.sel     = sel;
    s.typed     = 1'b0;
    s.want      = '0;
    return s;
  endfunction

  function automatic step_t map_known(logic [CP_W-1:0] cp, case_sel_t sel,
                                      logic [CP_W-1:0] mapped, logic found, logic err);
    step_t s;
    s       = map_step(cp, sel);
    s.typed = 1'b1;
    s.want  = {mapped, found, err};
    return s;
  endfunction

  function automatic step_t length_step(logic [LEN_W-1:0] len);
    step_t s;
    s.reg_write = 1'b1;
    s.len       = len;
    s.b         = random_beat();
    s.typed     = 1'b0;
    s.want      = '0;
    return s;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // one apb transfer to the length register, called at a falling edge
  task automatic cfg_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = LEN_ADDR;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // length changes only once the block has drained
  task automatic set_table_length(logic [LEN_W-1:0] len);
    logic [31:0] rd;
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_access(1'b1, 32'(len), rd);
    tbl_len = len;
    cfg_access(1'b0, '0, rd);
    if (rd[LEN_W-1:0] !== len) report_mismatch("table_length read-back", rd, len);
  endtask

  // drive one input beat from a falling edge, log its expectation on acceptance
  task automatic send_beat(beat_t b, bit typed, crm_result_t want);
    crm_result_t pred;
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tdata  = {6'b0, b.cp, b.dt, b.dl, b.du, b.hi, b.lo, b.idx};
    in_tuser  = {b.sel, b.func};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = case_map_predict(b);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // result sink with random stall bursts
  always @(negedge clk) begin
    if (sink_hold == 0) begin
      if (!quiet && out_tready && $urandom_range(0, 99) < sink_stall_pct) begin
        out_tready <= 1'b0;
        sink_hold  = $urandom_range(0, 11);
      end else begin
        out_tready <= 1'b1;
        sink_hold  = $urandom_range(0, 15);
      end
    end else begin
      sink_hold--;
    end
  end

  // compare each result beat with the oldest pending expectation
  always @(posedge clk) begin : result_check
    crm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[CP_W-1:0] !== want.mapped)
          report_mismatch("mapped_code_point", out_tdata[CP_W-1:0], want.mapped);
        if (out_tuser[0] !== want.found)
          report_mismatch("found", out_tuser[0], want.found);
        if (out_tuser[1] !== want.case_error)
          report_mismatch("case_error", out_tuser[1], want.case_error);
      end
    end
  end

  initial begin
    step_t steps[$];
    beat_t b;
    int    n_len;
    int    span;
    int    frontier;
    int    slot;
    int    pick;

    // sorted ranges spread over the whole code space, first and last pinned
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      plan_lo[i] = CP_W'(i * SLOT_SPAN + $urandom_range(0, 1000));
      plan_hi[i] = plan_lo[i] + CP_W'($urandom_range(0, 1000));
    end
    plan_lo[0]               = '0;
    plan_hi[TABLE_DEPTH - 1] = MAX_CP;

    // empty table after reset, invalid selector
    steps.push_back(map_known(21'h0, CASE_UPPER, 21'h0, 1'b0, 1'b0));
    steps.push_back(map_known(MAX_CP, CASE_LOWER, MAX_CP, 1'b0, 1'b0));
    steps.push_back(map_known(21'h1234, CASE_INVALID, REPLACEMENT_CP, 1'b0, 1'b1));
    // small table: plain deltas, alternating run, negative and wrapping deltas
    steps.push_back(load_step(9'd0, 21'h41, 21'h5A, 22'h0, 22'd32, 22'h0));
    steps.push_back(load_step(9'd1, 21'h100, 21'h12F, ALT_DELTA, ALT_DELTA, ALT_DELTA));
    steps.push_back(load_step(9'd2, 21'h10400, 21'h10427, 22'h0, 22'd40, 22'h0));
    steps.push_back(load_step(9'd3, 21'h10FF00, MAX_CP, 22'h2F0001, 22'h10FFFF, ALT_DELTA));
    steps.push_back(load_step(9'd511, MAX_CP, MAX_CP, 22'h3FFFFF, 22'h0, 22'h0));
    steps.push_back(length_step(10'd4));
    steps.push_back(map_step(21'h41, CASE_UPPER));
    steps.push_back(map_step(21'h41, CASE_LOWER));
    steps.push_back(map_step(21'h5A, CASE_TITLE));
    steps.push_back(map_step(21'h40, CASE_LOWER));
    steps.push_back(map_step(21'h5B, CASE_LOWER));
    steps.push_back(map_step(21'h101, CASE_UPPER));
    steps.push_back(map_step(21'h100, CASE_LOWER));
    steps.push_back(map_step(21'h12F, CASE_TITLE));
    steps.push_back(map_step(21'h10427, CASE_LOWER));
    steps.push_back(map_step(21'h10FF00, CASE_UPPER));
    steps.push_back(map_step(MAX_CP, CASE_LOWER));
    steps.push_back(map_step(MAX_CP, CASE_TITLE));
    steps.push_back(map_step(21'h200, CASE_UPPER));
    steps.push_back(map_known(21'h41, CASE_INVALID, REPLACEMENT_CP, 1'b0, 1'b1));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].reg_write) set_table_length(steps[i].len);
      else send_beat(steps[i].b, steps[i].typed, steps[i].want);
    end

    // random phases: the sorted layout fills in from slot 0 while the
    // searched length stays within the slots already loaded
    frontier = 0;
    for (int p = 0; p < PHASES; p++) begin
      if (p == FULL_PHASE) begin
        while (frontier < TABLE_DEPTH) begin
          send_beat(plan_beat(frontier), 1'b0, '0);
          frontier++;
        end
      end
      case (p)
        0:              n_len = 0;
        FULL_PHASE:     n_len = TABLE_DEPTH;
        FULL_PHASE + 1: n_len = (1 << LEN_W) - 1;
        PHASES - 1:     n_len = $urandom_range(1, TABLE_DEPTH);
        default:        n_len = $urandom_range(0, 1) ? frontier : $urandom_range(0, frontier);
      endcase
      set_table_length(LEN_W'(n_len));
      quiet          = (p == PHASES - 1);
      src_gap_pct    = 20 * $urandom_range(0, 2);
      sink_stall_pct = 20 * $urandom_range(0, 2);
      span           = (n_len > TABLE_DEPTH) ? TABLE_DEPTH : n_len;

      repeat (PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (frontier < TABLE_DEPTH && pick < 75) begin
          b = plan_beat(frontier);
          frontier++;
        end else begin
          b    = random_beat();
          pick = $urandom_range(0, 99);
          if (pick < 2) begin
            // stray entry, may break the sort order
            b.func = FUNC_LOAD;
          end else if (pick < 6) begin
            b = plan_beat($urandom_range(0, TABLE_DEPTH - 1));
          end else begin
            b.func = FUNC_MAP;
            if (pick < 10) begin
              b.sel = CASE_INVALID;
            end else if (span > 0 && pick < 85) begin
              // aim at a loaded range, its edges or just outside them
              slot = $urandom_range(0, span - 1);
              case ($urandom_range(0, 5))
                0: b.cp = lo_mem[slot];
                1: b.cp = hi_mem[slot];
                2: b.cp = lo_mem[slot] - CP_W'(1);
                3: b.cp = hi_mem[slot] + CP_W'(1);
                default: begin
                  if (lo_mem[slot] <= hi_mem[slot])
                    b.cp = lo_mem[slot] +
                           CP_W'($urandom_range(0, hi_mem[slot] - lo_mem[slot]));
                  else
                    b.cp = lo_mem[slot];
                end
              endcase
              if (b.cp > MAX_CP) b.cp = MAX_CP;
            end
          end
        end
        send_beat(b, 1'b0, '0);
      end
    end

    // drain, then allow for stray beats
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
